// ===== design/dclv_pkg.sv =====
// Package for the display command list validator.
// Holds the transaction structs, opcodes and decode classes; no dependencies.
package dclv_pkg;

  typedef struct packed {
    logic [31:0] word_high;
    logic [31:0] word_low;
    logic        last_command;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [11:0] insert_position;
  } out_item_t;

  localparam logic [7:0] OP_END      = 8'hdf;
  localparam logic [7:0] OP_TILESIZE = 8'hf2;
  localparam logic [7:0] OP_TILEDESC = 8'hf5;
  localparam logic [7:0] OP_VTX_A    = 8'h32;
  localparam logic [7:0] OP_VTX_B    = 8'h33;
  localparam logic [7:0] OP_DATA     = 8'h20;
  localparam logic [7:0] OP_TRI_A    = 8'h05;
  localparam logic [7:0] OP_TRI_B    = 8'h06;
  localparam logic [7:0] OP_TRI_C    = 8'h07;
  localparam logic [7:0] OP_TRI_D    = 8'h49;
  localparam logic [7:0] OP_VTX_C    = 8'h01;
  localparam logic [7:0] OP_VTX_D    = 8'h48;

  localparam logic [31:0] END_WORD      = 32'hdf000000;
  localparam logic [31:0] TILESIZE_WORD = 32'hf2000000;
  localparam logic [31:0] CAUSTIC_TILE1 = 32'h0107c07c;

  localparam logic [1:0] MAT_FOUNTAIN = 2'd1;
  localparam logic [1:0] MAT_CAUSTICS = 2'd2;

  localparam logic [0:0] REG_MATERIAL = 1'd0;
  localparam logic [0:0] REG_LARGE    = 1'd1;

  typedef enum logic [2:0] {
    K_END, K_PRIM, K_LOAD, K_VERTEX, K_TSIZE, K_TDESC, K_OTHER, K_BAD
  } kind_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  op;
    logic        end_words_ok;
    logic [2:0]  tile;
    logic        fnt_tsize_ok;
    logic        cau_tsize1_ok;
    logic        cau_tsize0_ok;
    logic        fnt_tdesc_ok;
    logic        cau_tdesc0_ok;
    logic        cau_tdesc1_ok;
    logic        last_command;
  } cmd_t;

endpackage

// ===== design/dclv_front.sv =====
// Front end: registers and classifies one command per transaction.
// Depends on dclv_pkg.
module dclv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              large_tiles,
  input  logic              in_valid,
  output logic              in_ready,
  input  dclv_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output dclv_pkg::cmd_t    cmd
);

  dclv_pkg::cmd_t c;
  logic [31:0] w0, w1;
  logic [11:0] e;
  logic [3:0]  mask;

  always_comb begin
    w0 = in_data.word_high;
    w1 = in_data.word_low;
    e = large_tiles ? 12'd252 : 12'd124;
    mask = large_tiles ? 4'd6 : 4'd5;
    c.op = w0[31:24];
    c.tile = w1[26:24];
    c.last_command = in_data.last_command;
    unique case (w0[31:24])
      dclv_pkg::OP_END: c.kind = dclv_pkg::K_END;
      dclv_pkg::OP_TRI_A, dclv_pkg::OP_TRI_B, dclv_pkg::OP_TRI_C,
      dclv_pkg::OP_TRI_D: c.kind = dclv_pkg::K_PRIM;
      dclv_pkg::OP_VTX_A, dclv_pkg::OP_VTX_B,
      dclv_pkg::OP_DATA: c.kind = dclv_pkg::K_LOAD;
      dclv_pkg::OP_VTX_C, dclv_pkg::OP_VTX_D: c.kind = dclv_pkg::K_VERTEX;
      dclv_pkg::OP_TILESIZE: c.kind = dclv_pkg::K_TSIZE;
      dclv_pkg::OP_TILEDESC: c.kind = dclv_pkg::K_TDESC;
      8'he7, 8'he8, 8'he6, 8'he3, 8'he2, 8'hd7, 8'hd9, 8'hf3, 8'hfc, 8'hfa,
      8'hfb: c.kind = dclv_pkg::K_OTHER;
      default: c.kind = dclv_pkg::K_BAD;
    endcase
    c.end_words_ok = (w0 == dclv_pkg::END_WORD) && (w1 == 32'd0);
    c.fnt_tsize_ok = (w0 == dclv_pkg::TILESIZE_WORD) &&
                     (w1 == {5'd0, w1[26:24], e, e});
    c.cau_tsize1_ok = (w0 == dclv_pkg::TILESIZE_WORD) && (w1 == dclv_pkg::CAUSTIC_TILE1);
    c.cau_tsize0_ok = (w1[23:12] >= w0[23:12]) && (w1[11:0] >= w0[11:0]);
    c.fnt_tdesc_ok = (w1[19:18] == 2'd0) && (w1[9:8] == 2'd0) &&
                     (w1[17:14] == mask) && (w1[7:4] == mask);
    c.cau_tdesc0_ok = (w0[8:0] == 9'd0);
    c.cau_tdesc1_ok = (w0[23:21] == 3'd0) && (w0[20:19] == 2'd2) &&
                      (w0[17:9] == 9'd8) && (w0[8:0] != 9'd0) &&
                      (w1[19:18] == 2'd0) && (w1[17:14] == 4'd5) &&
                      (w1[9:8] == 2'd0) && (w1[7:4] == 4'd5);
  end

  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd <= c;
    end
  end

endmodule

// ===== design/dclv_queue.sv =====
// Two-entry queue between front and back.
// Depends on dclv_pkg.
module dclv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dclv_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dclv_pkg::cmd_t rd_data
);

  dclv_pkg::cmd_t mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wp] <= wr_data;
  end

endmodule

// ===== design/dclv_back.sv =====
// Back end: carries the list state and issues the verdict.
// Depends on dclv_pkg.
module dclv_back #(
  parameter int MAX_COMMANDS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         material_class,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dclv_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output dclv_pkg::out_item_t out_data
);

  localparam int PW = $clog2(MAX_COMMANDS + 1);

  logic [PW-1:0] position, position_next;
  logic [1:0]    tile_sizes_seen, tile_sizes_seen_next;
  logic [1:0]    descriptors_seen, descriptors_seen_next;
  logic          primitive_seen, primitive_seen_next;
  logic [11:0]   primitive_index, primitive_index_next;
  logic          vertex_seen, vertex_seen_next;
  logic          skip_next, skip_next_next;
  logic          rejected, rejected_next;
  logic          good_end;
  logic [11:0]   where_pos, idx12;
  logic          fnt, cau, spc, bad, t1, ok;

  assign cmd_ready = !out_valid || out_ready;

  always_comb begin
    fnt = material_class == dclv_pkg::MAT_FOUNTAIN;
    cau = material_class == dclv_pkg::MAT_CAUSTICS;
    spc = fnt || cau;
    t1 = cmd.tile[0];
    idx12 = 12'(position);
    position_next = position;
    tile_sizes_seen_next = tile_sizes_seen;
    descriptors_seen_next = descriptors_seen;
    primitive_seen_next = primitive_seen;
    primitive_index_next = primitive_index;
    vertex_seen_next = vertex_seen;
    skip_next_next = skip_next;
    rejected_next = rejected;
    good_end = 1'b0;
    where_pos = 12'd0;
    bad = 1'b0;
    ok = 1'b0;
    if (position >= PW'(MAX_COMMANDS)) rejected_next = 1'b1;
    else position_next = position + 1'b1;
    if (skip_next) begin
      skip_next_next = 1'b0;
    end else if (!rejected_next) begin
      unique case (cmd.kind)
        dclv_pkg::K_END: begin
          ok = tile_sizes_seen == 2'd3 && (!spc || descriptors_seen == 2'd3) &&
               (!spc || cmd.end_words_ok);
          if (!cmd.last_command || !ok || (!primitive_seen && (!cau || vertex_seen)))
            rejected_next = 1'b1;
          else begin
            good_end = 1'b1;
            where_pos = primitive_seen ? primitive_index : idx12;
          end
        end
        dclv_pkg::K_PRIM: begin
          if (!primitive_seen) begin
            primitive_seen_next = 1'b1;
            primitive_index_next = idx12;
          end
        end
        dclv_pkg::K_LOAD: begin
          if (primitive_seen && cmd.op != dclv_pkg::OP_VTX_A) rejected_next = 1'b1;
          else begin
            if (cmd.op == dclv_pkg::OP_VTX_A) vertex_seen_next = 1'b1;
            skip_next_next = 1'b1;
          end
        end
        dclv_pkg::K_VERTEX: vertex_seen_next = 1'b1;
        dclv_pkg::K_TSIZE: begin
          if (primitive_seen) bad = 1'b1;
          else begin
            if (cmd.tile > 3'd1) bad = 1'b1;
            if (fnt && (tile_sizes_seen[t1] || !cmd.fnt_tsize_ok)) bad = 1'b1;
            if (cau && (tile_sizes_seen[t1] ||
                (t1 ? !cmd.cau_tsize1_ok : !cmd.cau_tsize0_ok))) bad = 1'b1;
            if (!bad) tile_sizes_seen_next[t1] = 1'b1;
          end
          if (bad) rejected_next = 1'b1;
        end
        dclv_pkg::K_TDESC: begin
          if (primitive_seen) bad = 1'b1;
          else if (spc && cmd.tile != 3'd7) begin
            if (cmd.tile > 3'd1 || descriptors_seen[t1]) bad = 1'b1;
            if (fnt && !cmd.fnt_tdesc_ok) bad = 1'b1;
            if (cau && (t1 ? !cmd.cau_tdesc1_ok : !cmd.cau_tdesc0_ok)) bad = 1'b1;
            if (!bad) descriptors_seen_next[t1] = 1'b1;
          end
          if (bad) rejected_next = 1'b1;
        end
        dclv_pkg::K_OTHER: if (primitive_seen) rejected_next = 1'b1;
        default: rejected_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      tile_sizes_seen <= '0;
      descriptors_seen <= '0;
      primitive_seen <= 1'b0;
      primitive_index <= '0;
      vertex_seen <= 1'b0;
      skip_next <= 1'b0;
      rejected <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd_valid && cmd_ready) begin
        if (cmd.last_command) begin
          position <= '0;
          tile_sizes_seen <= '0;
          descriptors_seen <= '0;
          primitive_seen <= 1'b0;
          primitive_index <= '0;
          vertex_seen <= 1'b0;
          skip_next <= 1'b0;
          rejected <= 1'b0;
          out_valid <= 1'b1;
          out_data.accepted <= good_end && !rejected_next;
          out_data.insert_position <= (good_end && !rejected_next) ? where_pos : 12'd0;
        end else begin
          position <= position_next;
          tile_sizes_seen <= tile_sizes_seen_next;
          descriptors_seen <= descriptors_seen_next;
          primitive_seen <= primitive_seen_next;
          primitive_index <= primitive_index_next;
          vertex_seen <= vertex_seen_next;
          skip_next <= skip_next_next;
          rejected <= rejected_next;
        end
      end
    end
  end

endmodule

// ===== design/display_command_list_validator.sv =====
// Top level of the display command list validator.
// Depends on dclv_pkg, dclv_front, dclv_queue and dclv_back.
//
// Accepts one 64-bit display command per cycle while the output is not
// stalled, and gives one verdict on the final command of each list. The
// front registers and decodes each command, a two-entry queue decouples it
// from the back, whose state update sets the sustained rate of one command
// per clock while the output is not stalled.
module display_command_list_validator #(
  parameter int MAX_COMMANDS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  dclv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dclv_pkg::out_item_t out_data
);

  logic [1:0] material_class;
  logic       large_tiles;
  logic       f_valid, f_ready, q_valid, q_ready;
  dclv_pkg::cmd_t f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      material_class <= 2'd0;
      large_tiles <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dclv_pkg::REG_MATERIAL: material_class <= cfg_data;
        dclv_pkg::REG_LARGE:    large_tiles <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dclv_front u_front (
    .clk, .rst, .large_tiles, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  dclv_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  dclv_back #(.MAX_COMMANDS(MAX_COMMANDS)) u_back (
    .clk, .rst, .material_class, .cmd_valid(q_valid), .cmd_ready(q_ready),
    .cmd(q_cmd), .out_valid, .out_ready, .out_data
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for display_command_list_validator: directed table, then random lists.
// Depends on dclv_pkg and the validator RTL; checks each verdict against a local predictor.
module tb_top;
  import dclv_pkg::*;

  localparam int MAXC = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  display_command_list_validator #(.MAX_COMMANDS(MAXC)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  logic [1:0] mat_cls;
  logic big_tiles;
  int unsigned lst_pos;
  logic [1:0] tsz_seen, tdesc_seen;
  logic prim_seen, vtx_seen, skip_pl, lst_bad;
  logic [11:0] prim_idx;

  out_item_t verdicts[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;

  typedef struct {
    in_item_t cmd;
    logic has_exp;
    out_item_t exp;
  } row_t;

  function automatic logic setup_ok(logic [7:0] op, logic [31:0] w0, logic [31:0] w1);
    logic fnt, cau;
    logic [31:0] dim, msk, tile, e;
    fnt = (mat_cls == MAT_FOUNTAIN);
    cau = (mat_cls == MAT_CAUSTICS);
    dim = big_tiles ? 64 : 32;
    msk = big_tiles ? 6 : 5;
    tile = (w1 >> 24) & 7;
    case (op)
      OP_TILESIZE: begin
        if (tile > 1) return 1'b0;
        if (fnt) begin
          e = (dim - 1) * 4;
          if (tsz_seen[tile] || w0 != TILESIZE_WORD || w1 != ((tile << 24) | (e << 12) | e))
            return 1'b0;
        end
        if (cau) begin
          if (tsz_seen[tile]) return 1'b0;
          if (tile == 1) begin
            if (w0 != TILESIZE_WORD || w1 != CAUSTIC_TILE1) return 1'b0;
          end else if (w1[23:12] < w0[23:12] || w1[11:0] < w0[11:0]) begin
            return 1'b0;
          end
        end
        tsz_seen[tile] = 1'b1;
        return 1'b1;
      end
      OP_TILEDESC: begin
        if (!fnt && !cau) return 1'b1;
        if (tile == 7) return 1'b1;
        if (tile > 1 || tdesc_seen[tile]) return 1'b0;
        if (fnt && (w1[19:18] != 0 || w1[9:8] != 0 || w1[17:14] != msk || w1[7:4] != msk))
          return 1'b0;
        if (cau) begin
          if (tile == 0 && w0[8:0] != 0) return 1'b0;
          if (tile == 1 && (w0[23:21] != 0 || w0[20:19] != 2 || w0[17:9] != 8 ||
              w0[8:0] == 0 || w1[19:18] != 0 || w1[17:14] != 5 || w1[9:8] != 0 ||
              w1[7:4] != 5))
            return 1'b0;
        end
        tdesc_seen[tile] = 1'b1;
        return 1'b1;
      end
      8'he7, 8'he8, 8'he6, 8'he3, 8'he2, 8'hd7, 8'hd9, 8'hf3, 8'hfc, 8'hfa, 8'hfb:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_list();
    lst_pos = 0; tsz_seen = 0; tdesc_seen = 0; prim_seen = 0; prim_idx = 0;
    vtx_seen = 0; skip_pl = 0; lst_bad = 0;
  endtask

  task automatic predict_verdict(input in_item_t c);
    logic [7:0] op;
    logic fnt, cau, spc, good, sok;
    int unsigned idx;
    logic [11:0] where;
    op = c.word_high[31:24];
    fnt = (mat_cls == MAT_FOUNTAIN);
    cau = (mat_cls == MAT_CAUSTICS);
    spc = fnt || cau;
    idx = lst_pos;
    good = 1'b0;
    where = '0;
    if (lst_pos >= MAXC) lst_bad = 1'b1;
    else lst_pos++;
    if (skip_pl) begin
      skip_pl = 1'b0;
    end else if (!lst_bad) begin
      if (op == OP_END) begin
        sok = tsz_seen == 2'd3 && (!spc || tdesc_seen == 2'd3) &&
              (!spc || (c.word_high == END_WORD && c.word_low == 0));
        if (!c.last_command || !sok || (!prim_seen && (!cau || vtx_seen))) begin
          lst_bad = 1'b1;
        end else begin
          good = 1'b1;
          where = prim_seen ? prim_idx : idx[11:0];
        end
      end else if (op == OP_TRI_A || op == OP_TRI_B || op == OP_TRI_C || op == OP_TRI_D) begin
        if (!prim_seen) begin
          prim_seen = 1'b1;
          prim_idx = idx[11:0];
        end
      end else if (op == OP_VTX_A || op == OP_VTX_B || op == OP_DATA) begin
        if (prim_seen && op != OP_VTX_A) lst_bad = 1'b1;
        else begin
          if (op == OP_VTX_A) vtx_seen = 1'b1;
          skip_pl = 1'b1;
        end
      end else if (op == OP_VTX_C || op == OP_VTX_D) begin
        vtx_seen = 1'b1;
      end else if (prim_seen) begin
        lst_bad = 1'b1;
      end else if (!setup_ok(op, c.word_high, c.word_low)) begin
        lst_bad = 1'b1;
      end
    end
    if (c.last_command) begin
      if (good && !lst_bad) verdicts.push_back('{accepted: 1'b1, insert_position: where});
      else verdicts.push_back('{accepted: 1'b0, insert_position: 12'd0});
      clear_list();
    end
  endtask

  task automatic send_cmd(input in_item_t c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(c);
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    while (n < 10) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MATERIAL) mat_cls = val;
    else big_tiles = val[0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdicts.size() == 0) begin
        $error("unexpected verdict %p", out_data);
        errors++;
      end else begin
        if (out_data.accepted !== verdicts[0].accepted) begin
          $error("accepted: expected %0d actual %0d", verdicts[0].accepted, out_data.accepted);
          errors++;
        end
        if (out_data.insert_position !== verdicts[0].insert_position) begin
          $error("insert_position: expected %0d actual %0d",
                 verdicts[0].insert_position, out_data.insert_position);
          errors++;
        end
        void'(verdicts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(99) < recv_idle);
    end
  end

  function automatic in_item_t mk(logic [31:0] hi, logic [31:0] lo, logic l);
    in_item_t c;
    c.word_high = hi;
    c.word_low = lo;
    c.last_command = l;
    return c;
  endfunction

  function automatic logic [31:0] tsz_lo(int t);
    logic [31:0] e;
    e = big_tiles ? 252 : 124;
    if (mat_cls == MAT_CAUSTICS && t == 1) return CAUSTIC_TILE1;
    return (t << 24) | (e << 12) | e;
  endfunction

  function automatic logic [31:0] tdesc_lo(int t);
    logic [31:0] m;
    m = (mat_cls == MAT_FOUNTAIN) ? (big_tiles ? 6 : 5) : 5;
    return (t << 24) | (m << 14) | (m << 4);
  endfunction

  function automatic logic [31:0] tdesc_hi(int t);
    if (mat_cls == MAT_CAUSTICS && t == 1)
      return {OP_TILEDESC, 3'd0, 2'd2, 1'b0, 9'd8, 9'($urandom_range(1, 511))};
    if (mat_cls == MAT_CAUSTICS) return {OP_TILEDESC, 15'($urandom), 9'd0};
    return {OP_TILEDESC, 24'($urandom)};
  endfunction

  function automatic logic [31:0] noise_word(logic [31:0] w);
    if ($urandom_range(9) == 0) return w ^ (32'd1 << $urandom_range(31));
    return w;
  endfunction

  task automatic send_list(input int mode);
    int n, k, t;
    logic [7:0] op;
    static logic [7:0] misc_ops[11] = '{8'he7, 8'he8, 8'he6, 8'he3, 8'he2, 8'hd7, 8'hd9,
                                        8'hf3, 8'hfc, 8'hfa, 8'hfb};
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) send_cmd(mk({misc_ops[$urandom_range(10)], 24'($urandom)},
                                         $urandom, 1'b0));
    for (t = 0; t < 2; t++) begin
      send_cmd(mk(mode ? noise_word(TILESIZE_WORD) : TILESIZE_WORD,
                  mode ? noise_word(tsz_lo(t)) : tsz_lo(t), 1'b0));
      send_cmd(mk(mode ? noise_word(tdesc_hi(t)) : tdesc_hi(t),
                  mode ? noise_word(tdesc_lo(t)) : tdesc_lo(t), 1'b0));
    end
    n = $urandom_range(0, 4);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: op = OP_VTX_A;
        1: op = OP_VTX_B;
        2: op = OP_DATA;
        default: op = OP_VTX_D;
      endcase
      send_cmd(mk({op, 24'($urandom)}, $urandom, 1'b0));
      if (op != OP_VTX_D) send_cmd(mk($urandom, $urandom, 1'b0));
    end
    if ($urandom_range(4) != 0) begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(4))
          0: op = OP_TRI_A;
          1: op = OP_TRI_B;
          2: op = OP_TRI_C;
          3: op = OP_TRI_D;
          default: op = OP_VTX_A;
        endcase
        send_cmd(mk({op, 24'($urandom)}, $urandom, 1'b0));
        if (op == OP_VTX_A) send_cmd(mk($urandom, $urandom, 1'b0));
      end
    end
    if (mode && $urandom_range(3) == 0) send_cmd(mk($urandom, $urandom, $urandom_range(1)));
    send_cmd(mk(mode ? noise_word(END_WORD) : END_WORD, mode ? noise_word(0) : 32'd0, 1'b1));
  endtask

  row_t dir_rows[$];
  int sent;

  initial begin
    mat_cls = 0;
    big_tiles = 0;
    clear_list();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows.push_back('{mk(END_WORD, 0, 1'b1), 1'b1, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(32'hffffffff, 32'hffffffff, 1'b1), 1'b1, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(32'h00000000, 32'h00000000, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(END_WORD, 0, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(END_WORD, 0, 1'b1), 1'b1, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(TILESIZE_WORD, 32'h0, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(TILESIZE_WORD, 32'h01000000, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk({OP_TRI_A, 24'h0}, 0, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(32'hdfffffff, 32'hffffffff, 1'b1), 1'b1, '{1'b1, 12'd2}});
    dir_rows.push_back('{mk({OP_VTX_A, 24'h0}, 0, 1'b1), 1'b1, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk({OP_DATA, 24'h0}, 0, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(END_WORD, 0, 1'b1), 1'b1, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(TILESIZE_WORD, 32'h0, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(TILESIZE_WORD, 32'h01000000, 1'b0), 1'b0, '{1'b0, 12'd0}});
    dir_rows.push_back('{mk(END_WORD, 0, 1'b1), 1'b1, '{1'b0, 12'd0}});
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd);
      if (dir_rows[i].has_exp && verdicts.size() > 0 &&
          verdicts[$] !== dir_rows[i].exp) begin
        $error("directed row %0d: expected %p predicted %p", i, dir_rows[i].exp, verdicts[$]);
        errors++;
      end
    end
    wait_drain();

    write_cfg(REG_MATERIAL, 2'd3);
    send_cmd(mk({OP_TILEDESC, 24'h0}, 32'h05000000, 1'b0));
    send_cmd(mk(END_WORD, 0, 1'b1));
    wait_drain();

    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(REG_MATERIAL, 2'(ph % 4));
      write_cfg(REG_LARGE, 2'((ph / 4) % 2));
      if (ph < 4) begin send_idle = 10; recv_idle = 48; end
      else if (ph < 8) begin send_idle = 48; recv_idle = 10; end
      else begin send_idle = 0; recv_idle = 0; end
      if (ph == 2) hold_cycles = 300;
      for (int k = 0; k < 7; k++) begin
        send_list($urandom_range(2) == 0);
        sent++;
      end
      if (ph == 5) wait_drain();
      wait_drain();
    end

    wait_drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
